// File: rtl/triple_union_component_labeler_core_defines.svh
// Assertion macros for the triple-union component labeler.
// Each expects clk and rst_n in scope; the bodies are empty under SYNTHESIS.
`ifndef TRIPLE_UNION_COMPONENT_LABELER_CORE_DEFINES_SVH
`define TRIPLE_UNION_COMPONENT_LABELER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define TUCL_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tucl: assertion failed");
// Next-cycle implication.
`define TUCL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tucl: assertion failed");
`else
`define TUCL_ASSERT_IMPL(lbl, ante, cons)
`define TUCL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/tucl_pkg.sv
// Shared types and codes for the triple-union component labeler.
// No dependencies.
package tucl_pkg;

    localparam int ID_W    = 10;
    localparam int LABEL_W = 11;
    localparam int OUTC_W  = 3;

    localparam logic [LABEL_W-1:0] LABEL_MAX = 11'd2047;
    localparam logic [ID_W-1:0]    LIMIT_RST = 10'd1023;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [OUTC_W-1:0] OUTC_NEW   = 3'd0;
    localparam logic [OUTC_W-1:0] OUTC_JOIN  = 3'd1;
    localparam logic [OUTC_W-1:0] OUTC_MERGE = 3'd2;
    localparam logic [OUTC_W-1:0] OUTC_ERR   = 3'd3;
    localparam logic [OUTC_W-1:0] OUTC_QUERY = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic clear;        // write zero at scan counter, advance it
        logic capture;      // take the item, read the table at node_a
        logic rd_b;         // keep label of a, read node_b
        logic rd_c;         // keep label of b, read node_c
        logic eval;         // resolve labels, write node_a
        logic wr_b;
        logic wr_c;
        logic sweep_start;
        logic sweep;        // relabel pass over the whole table
        logic set_err;
        logic set_query;
        logic load_out;
    } tucl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;
        logic scan_end;
        logic is_query;
        logic range_err;
        logic merge;
        logic out_free;
    } tucl_sts_t;

endpackage

// File: rtl/triple_union_component_labeler_core.sv
// Top level of the triple-union component labeler: controller plus datapath.
// Depends on tucl_pkg, tucl_ctrl and tucl_dpath.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  input    | in_valid / in_stall | command, node_a, node_b, node_c
//  output   | out_valid/out_stall | group_label, outcome
//  config   | cfg_wr_en           | cfg_wr_data (node_limit)
//
// After reset the label table is cleared one entry a cycle, with in_stall high
// until the pass ends. A query or a rejected row reads the table at node_a only;
// an add reads node_a, node_b and node_c, then writes all three in that order.
// A merging add then makes a relabel pass over the whole table. The output register
// lets the next item be accepted while a result is stalled.
module triple_union_component_labeler_core
    import tucl_pkg::*;
#(
    parameter int NODE_COUNT = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic [ID_W-1:0]     node_a,
    input  logic [ID_W-1:0]     node_b,
    input  logic [ID_W-1:0]     node_c,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [LABEL_W-1:0]  group_label,
    output logic [OUTC_W-1:0]   outcome,
    input  logic                cfg_wr_en,
    input  logic [ID_W-1:0]     cfg_wr_data
);

    tucl_cmd_t cmd;
    tucl_sts_t sts;

    tucl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    tucl_dpath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .command     (command),
        .node_a      (node_a),
        .node_b      (node_b),
        .node_c      (node_c),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .group_label (group_label),
        .outcome     (outcome)
    );

endmodule

// File: rtl/tucl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tucl_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/tucl_ctrl.sv
// Sequencer for the labeler: clearing pass, lookups, writes, relabel pass.
// Depends on tucl_pkg.
module tucl_ctrl
    import tucl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  tucl_sts_t sts,
    output tucl_cmd_t cmd
);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_RD_B  = 9'b000000100,
        S_RD_C  = 9'b000001000,
        S_EVAL  = 9'b000010000,
        S_WR_B  = 9'b000100000,
        S_WR_C  = 9'b001000000,
        S_SWEEP = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = S_RD_B;
                end
            end
            S_RD_B:
            begin
                // label of node_a is on the read port now
                if (sts.is_query)
                begin
                    cmd.set_query = 1'b1;
                    state_next    = S_DONE;
                end
                else if (sts.range_err)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.rd_b   = 1'b1;
                    state_next = S_RD_C;
                end
            end
            S_RD_C:
            begin
                cmd.rd_c   = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_WR_B;
            end
            S_WR_B:
            begin
                cmd.wr_b   = 1'b1;
                state_next = S_WR_C;
            end
            S_WR_C:
            begin
                cmd.wr_c = 1'b1;
                if (sts.merge)
                begin
                    cmd.sweep_start = 1'b1;
                    state_next      = S_SWEEP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (sts.scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// File: rtl/tucl_dpath.sv
// Datapath of the labeler: label table, item and label registers, counters,
// result and output registers. Depends on tucl_pkg, tucl_ram and the defines.
`include "triple_union_component_labeler_core_defines.svh"

module tucl_dpath
    import tucl_pkg::*;
#(
    parameter int NODE_COUNT = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tucl_cmd_t           cmd,
    output tucl_sts_t           sts,
    input  logic                command,
    input  logic [ID_W-1:0]     node_a,
    input  logic [ID_W-1:0]     node_b,
    input  logic [ID_W-1:0]     node_c,
    input  logic                cfg_wr_en,
    input  logic [ID_W-1:0]     cfg_wr_data,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [LABEL_W-1:0]  group_label,
    output logic [OUTC_W-1:0]   outcome
);

    localparam int AW = $clog2(NODE_COUNT);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] SCAN_END  = CW'(NODE_COUNT);
    localparam logic [CW-1:0] SCAN_LAST = CW'(NODE_COUNT - 1);

    function automatic logic id_ok(input logic [ID_W-1:0] id,
                                   input logic [ID_W-1:0] limit);
        return (id <= limit) && (32'(id) < NODE_COUNT);
    endfunction

    // smaller of two labels, zero meaning none
    function automatic logic [LABEL_W-1:0] min_nz(input logic [LABEL_W-1:0] x,
                                                  input logic [LABEL_W-1:0] y);
        logic [LABEL_W-1:0] m;
        if (x == '0)
        begin
            m = y;
        end
        else if (y == '0)
        begin
            m = x;
        end
        else
        begin
            m = (x < y) ? x : y;
        end
        return m;
    endfunction

    logic                command_reg;
    logic [ID_W-1:0]     a_reg;
    logic [ID_W-1:0]     b_reg;
    logic [ID_W-1:0]     c_reg;
    logic [ID_W-1:0]     node_limit_reg;
    logic [LABEL_W-1:0]  la_reg;
    logic [LABEL_W-1:0]  lb_reg;
    logic [LABEL_W-1:0]  low_reg;
    logic [LABEL_W-1:0]  los_a_reg;
    logic [LABEL_W-1:0]  los_b_reg;
    logic [LABEL_W-1:0]  los_c_reg;
    logic                merge_reg;
    logic [LABEL_W-1:0]  next_label_reg;
    logic [CW-1:0]       scan_cnt_reg;
    logic                sweep_pend_reg;
    logic [AW-1:0]       sweep_addr_reg;
    logic [LABEL_W-1:0]  res_label_reg;
    logic [OUTC_W-1:0]   res_outc_reg;
    logic [LABEL_W-1:0]  out_label_reg;
    logic [OUTC_W-1:0]   out_outc_reg;
    logic                out_valid_reg;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [LABEL_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [LABEL_W-1:0]  ram_rdata;

    logic [LABEL_W-1:0]  lc;
    logic [LABEL_W-1:0]  low_found;
    logic                any_label;
    logic                all_same;
    logic [LABEL_W-1:0]  fresh_label;
    logic [LABEL_W-1:0]  eval_low;
    logic [OUTC_W-1:0]   eval_outc;
    logic                range_err;
    logic                sweep_hit;
    logic                sweep_rd;

    tucl_ram #(
        .WIDTH (LABEL_W),
        .DEPTH (NODE_COUNT)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // label resolution on the three looked-up labels
    always_comb
    begin
        lc          = ram_rdata;
        low_found   = min_nz(min_nz(la_reg, lb_reg), lc);
        any_label   = (la_reg != '0) || (lb_reg != '0) || (lc != '0);
        all_same    = ((la_reg == '0) || (la_reg == low_found)) &&
                      ((lb_reg == '0) || (lb_reg == low_found)) &&
                      ((lc == '0) || (lc == low_found));
        fresh_label = (next_label_reg != LABEL_MAX) ? next_label_reg + 1'b1
                                                    : next_label_reg;
        if (!any_label)
        begin
            eval_low  = fresh_label;
            eval_outc = OUTC_NEW;
        end
        else if (all_same)
        begin
            eval_low  = low_found;
            eval_outc = OUTC_JOIN;
        end
        else
        begin
            eval_low  = low_found;
            eval_outc = OUTC_MERGE;
        end
    end

    always_comb
    begin
        if (command_reg == CMD_QUERY)
        begin
            range_err = !id_ok(a_reg, node_limit_reg);
        end
        else
        begin
            range_err = !(id_ok(a_reg, node_limit_reg) &&
                          id_ok(b_reg, node_limit_reg) &&
                          id_ok(c_reg, node_limit_reg));
        end
    end

    // a zero entry never matches, so unused loser slots hold zero
    assign sweep_hit = (ram_rdata != '0) &&
                       ((ram_rdata == los_a_reg) || (ram_rdata == los_b_reg) ||
                        (ram_rdata == los_c_reg));
    assign sweep_rd  = cmd.sweep && (scan_cnt_reg != SCAN_END);

    // table port selection
    always_comb
    begin
        ram_re    = cmd.capture || cmd.rd_b || cmd.rd_c || sweep_rd;
        ram_raddr = AW'(node_a);
        if (cmd.rd_b)
        begin
            ram_raddr = AW'(b_reg);
        end
        else if (cmd.rd_c)
        begin
            ram_raddr = AW'(c_reg);
        end
        else if (cmd.sweep)
        begin
            ram_raddr = scan_cnt_reg[AW-1:0];
        end

        ram_we    = 1'b0;
        ram_waddr = scan_cnt_reg[AW-1:0];
        ram_wdata = low_reg;
        if (cmd.clear)
        begin
            ram_we    = 1'b1;
            ram_wdata = '0;
        end
        else if (cmd.eval)
        begin
            ram_we    = 1'b1;
            ram_waddr = AW'(a_reg);
            ram_wdata = eval_low;
        end
        else if (cmd.wr_b)
        begin
            ram_we    = 1'b1;
            ram_waddr = AW'(b_reg);
        end
        else if (cmd.wr_c)
        begin
            ram_we    = 1'b1;
            ram_waddr = AW'(c_reg);
        end
        else if (cmd.sweep)
        begin
            ram_we    = sweep_pend_reg && sweep_hit;
            ram_waddr = sweep_addr_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_limit_reg <= LIMIT_RST;
            next_label_reg <= '0;
            scan_cnt_reg   <= '0;
            sweep_pend_reg <= 1'b0;
            merge_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                node_limit_reg <= cfg_wr_data;
            end
            if (cmd.eval)
            begin
                merge_reg <= (eval_outc == OUTC_MERGE);
                if (eval_outc == OUTC_NEW)
                begin
                    next_label_reg <= fresh_label;
                end
            end
            if (cmd.sweep_start)
            begin
                scan_cnt_reg <= '0;
            end
            else if (cmd.clear || sweep_rd)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            sweep_pend_reg <= sweep_rd;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            command_reg <= command;
            a_reg       <= node_a;
            b_reg       <= node_b;
            c_reg       <= node_c;
        end
        if (cmd.rd_b)
        begin
            la_reg <= ram_rdata;
        end
        if (cmd.rd_c)
        begin
            lb_reg <= ram_rdata;
        end
        if (cmd.eval)
        begin
            low_reg       <= eval_low;
            los_a_reg     <= (la_reg != eval_low) ? la_reg : '0;
            los_b_reg     <= (lb_reg != eval_low) ? lb_reg : '0;
            los_c_reg     <= (lc != eval_low) ? lc : '0;
            res_label_reg <= eval_low;
            res_outc_reg  <= eval_outc;
        end
        if (cmd.set_err)
        begin
            res_label_reg <= '0;
            res_outc_reg  <= OUTC_ERR;
        end
        if (cmd.set_query)
        begin
            res_label_reg <= range_err ? '0 : ram_rdata;
            res_outc_reg  <= range_err ? OUTC_ERR : OUTC_QUERY;
        end
        if (cmd.sweep)
        begin
            sweep_addr_reg <= scan_cnt_reg[AW-1:0];
        end
        if (cmd.load_out)
        begin
            out_label_reg <= res_label_reg;
            out_outc_reg  <= res_outc_reg;
        end
    end

    always_comb
    begin
        sts.scan_last = (scan_cnt_reg == SCAN_LAST);
        sts.scan_end  = (scan_cnt_reg == SCAN_END);
        sts.is_query  = (command_reg == CMD_QUERY);
        sts.range_err = range_err;
        sts.merge     = merge_reg;
        sts.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid   = out_valid_reg;
    assign group_label = out_label_reg;
    assign outcome     = out_outc_reg;

    `TUCL_ASSERT_IMPL(a_out_drop_only_when_taken, $fell(out_valid_reg), $past(!out_stall))
    `TUCL_ASSERT_NEXT(a_label_never_falls, 1'b1, next_label_reg >= $past(next_label_reg))
    `TUCL_ASSERT_IMPL(a_group_label_set, out_valid_reg && (out_outc_reg == OUTC_NEW || out_outc_reg == OUTC_JOIN || out_outc_reg == OUTC_MERGE), out_label_reg != '0)
    `TUCL_ASSERT_IMPL(a_no_zero_label_write, ram_we && !cmd.clear, ram_wdata != '0)

endmodule

// File: sim/tb_triple_union_component_labeler_core.sv
// Self-checking bench for triple_union_component_labeler_core: row adds and label
// queries are checked against an in-bench label table, under random idling and hold-off.
// Depends on tucl_pkg and the RTL of the labeler core.
`timescale 1ns / 100ps

module tb_triple_union_component_labeler_core;
    import tucl_pkg::*;

    localparam int NODE_COUNT   = 1024;
    localparam int RUN_LIMIT    = 8_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = NODE_COUNT + 32;

    typedef struct packed {
        logic            command;
        logic [ID_W-1:0] node_a;
        logic [ID_W-1:0] node_b;
        logic [ID_W-1:0] node_c;
    } row_t;

    typedef struct packed {
        logic [LABEL_W-1:0] group_label;
        logic [OUTC_W-1:0]  outcome;
    } group_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               command;
    logic [ID_W-1:0]    node_a;
    logic [ID_W-1:0]    node_b;
    logic [ID_W-1:0]    node_c;
    logic               out_valid;
    logic               out_stall;
    logic [LABEL_W-1:0] group_label;
    logic [OUTC_W-1:0]  outcome;
    logic               cfg_wr_en;
    logic [ID_W-1:0]    cfg_wr_data;

    // Bench copy of the block state
    logic [LABEL_W-1:0] label_of [NODE_COUNT];
    logic [LABEL_W-1:0] last_label;
    logic [ID_W-1:0]    limit_now;

    row_t          pending_rows[$];
    group_result_t expected_groups[$];

    bit  row_taken;
    bit  hold_arm;
    int  hold_left;
    int  send_gap_pct;
    int  stall_pct;
    int  cycle_count;
    int  fail_count;
    int  rows_accepted;
    int  limit_writes;
    int  outcome_seen [8];

    triple_union_component_labeler_core #(
        .NODE_COUNT(NODE_COUNT)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .node_a     (node_a),
        .node_b     (node_b),
        .node_c     (node_c),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .group_label(group_label),
        .outcome    (outcome),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit id_accepted(logic [ID_W-1:0] id);
        return (id <= limit_now) && (int'(id) < NODE_COUNT);
    endfunction

    // Apply one row to the label table and return the result it should produce
    function automatic group_result_t resolve_row(row_t r);
        logic [ID_W-1:0]    ids [3];
        logic [LABEL_W-1:0] found [3];
        logic [LABEL_W-1:0] lab;
        logic [LABEL_W-1:0] winner;
        int                 distinct;
        bit                 dup;
        group_result_t      res;
        ids[0] = r.node_a;
        ids[1] = r.node_b;
        ids[2] = r.node_c;
        winner = '0;
        distinct = 0;
        res.group_label = '0;
        res.outcome = OUTC_ERR;
        if (r.command == CMD_QUERY)
        begin
            if (id_accepted(ids[0]))
            begin
                res.group_label = label_of[ids[0]];
                res.outcome = OUTC_QUERY;
            end
            return res;
        end
        if (!id_accepted(ids[0]) || !id_accepted(ids[1]) || !id_accepted(ids[2]))
            return res;
        for (int k = 0; k < 3; k++)
        begin
            lab = label_of[ids[k]];
            found[k] = '0;
            dup = 1'b0;
            for (int j = 0; j < k; j++)
                if (found[j] == lab)
                    dup = 1'b1;
            if (lab != '0 && !dup)
            begin
                found[k] = lab;
                distinct++;
                if (winner == '0 || lab < winner)
                    winner = lab;
            end
        end
        if (distinct == 0)
        begin
            // saturate rather than wrap once labels run out
            if (last_label < LABEL_MAX)
                last_label++;
            winner = last_label;
            res.outcome = OUTC_NEW;
        end
        else if (distinct == 1)
        begin
            res.outcome = OUTC_JOIN;
        end
        else
        begin
            for (int k = 0; k < 3; k++)
                if (found[k] != '0 && found[k] != winner)
                    for (int i = 0; i < NODE_COUNT; i++)
                        if (label_of[i] == found[k])
                            label_of[i] = winner;
            res.outcome = OUTC_MERGE;
        end
        for (int k = 0; k < 3; k++)
            label_of[ids[k]] = winner;
        res.group_label = winner;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    endtask

    // Input acceptance, register tracking and result checking
    always @(posedge clk)
    begin : accept_and_check
        row_t          row;
        group_result_t want;
        if (rst_n)
        begin
            if (cfg_wr_en)
                limit_now = cfg_wr_data;
            if (in_valid && !in_stall)
            begin
                row = pending_rows.pop_front();
                expected_groups = {expected_groups, resolve_row(row)};
                rows_accepted++;
                row_taken = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                outcome_seen[outcome]++;
                if (expected_groups.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result label %0d outcome %0d",
                                              group_label, outcome));
                end
                else
                begin
                    want = expected_groups.pop_front();
                    if (group_label !== want.group_label)
                        report_mismatch($sformatf("group_label %0d, expected %0d",
                                                  group_label, want.group_label));
                    if (outcome !== want.outcome)
                        report_mismatch($sformatf("outcome %0d, expected %0d",
                                                  outcome, want.outcome));
                end
            end
        end
    end

    // Row driver: hold a stalled item, otherwise offer the next one or idle
    always @(negedge clk)
    begin
        if (!in_valid || row_taken)
        begin
            row_taken = 1'b0;
            if (rst_n && pending_rows.size() != 0 &&
                $urandom_range(99) >= send_gap_pct)
            begin
                in_valid <= 1'b1;
                command  <= pending_rows[0].command;
                node_a   <= pending_rows[0].node_a;
                node_b   <= pending_rows[0].node_b;
                node_c   <= pending_rows[0].node_c;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Long output hold-off, counted down on its own
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_arm)
        begin
            hold_left <= HOLD_CYCLES;
            hold_arm = 1'b0;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("triple_union_component_labeler_core verification failed");
            $finish;
        end
    end

    task automatic add_row(logic cmd, int a, int b, int c);
        row_t r;
        r.command = cmd;
        r.node_a = ID_W'(a);
        r.node_b = ID_W'(b);
        r.node_c = ID_W'(c);
        pending_rows = {pending_rows, r};
    endtask

    task automatic settle();
        while (pending_rows.size() != 0 || expected_groups.size() != 0)
            @(posedge clk);
    endtask

    // Only called with nothing in flight
    task automatic write_limit(int value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ID_W'(value);
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        limit_writes++;
    endtask

    // Mostly in-range adds with id reuse to build joins and merges, plus queries
    // and, where the limit allows it, rows that break the range
    task automatic queue_random(int count, int lim);
        row_t             r;
        int               pick;
        logic [ID_W-1:0]  recent [4];
        for (int i = 0; i < 4; i++)
            recent[i] = ID_W'($urandom_range(lim));
        repeat (count)
        begin
            pick = $urandom_range(99);
            r.command = (pick < 15) ? CMD_QUERY : CMD_ADD;
            r.node_a = ID_W'($urandom_range(lim));
            r.node_b = ID_W'($urandom_range(lim));
            r.node_c = ID_W'($urandom_range(lim));
            if ($urandom_range(3) == 0)
                r.node_a = recent[$urandom_range(3)];
            if ($urandom_range(3) == 0)
                r.node_b = recent[$urandom_range(3)];
            if ($urandom_range(4) == 0)
                r.node_c = r.node_a;
            if (r.command == CMD_QUERY)
            begin
                r.node_b = ID_W'($urandom_range(1023));
                r.node_c = ID_W'($urandom_range(1023));
                if ($urandom_range(1) == 0)
                    r.node_a = ID_W'($urandom_range(1023));
            end
            else if (pick < 25 && lim < 1023)
            begin
                case ($urandom_range(2))
                    0: r.node_a = ID_W'($urandom_range(1023, lim + 1));
                    1: r.node_b = ID_W'($urandom_range(1023, lim + 1));
                    default: r.node_c = ID_W'($urandom_range(1023, lim + 1));
                endcase
            end
            recent[$urandom_range(3)] = r.node_b;
            recent[$urandom_range(3)] = r.node_a;
            pending_rows = {pending_rows, r};
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = CMD_ADD;
        node_a       = '0;
        node_b       = '0;
        node_c       = '0;
        out_stall    = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        row_taken    = 1'b0;
        hold_arm     = 1'b0;
        hold_left    = 0;
        send_gap_pct = 0;
        stall_pct    = 0;
        cycle_count  = 0;
        fail_count   = 0;
        foreach (label_of[i])
            label_of[i] = '0;
        last_label = '0;
        limit_now  = LIMIT_RST;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        write_limit(1023);

        // Directed: unlabeled query, new groups at both ends of the id range,
        // duplicate ids, a join, two- and three-way merges
        add_row(CMD_QUERY, 0, 1023, 1023);
        add_row(CMD_ADD, 0, 0, 0);
        add_row(CMD_ADD, 1023, 1022, 1021);
        add_row(CMD_ADD, 0, 5, 6);
        add_row(CMD_ADD, 5, 1023, 7);
        add_row(CMD_QUERY, 1021, 0, 0);
        add_row(CMD_ADD, 100, 101, 102);
        add_row(CMD_ADD, 200, 201, 202);
        add_row(CMD_ADD, 300, 301, 302);
        add_row(CMD_ADD, 102, 202, 302);
        add_row(CMD_ADD, 102, 0, 300);
        add_row(CMD_QUERY, 202, 0, 0);
        add_row(CMD_ADD, 682, 341, 682);
        settle();

        // Tightest limit: only id 0 passes
        write_limit(0);
        add_row(CMD_ADD, 0, 0, 0);
        add_row(CMD_ADD, 0, 1, 0);
        add_row(CMD_ADD, 0, 0, 1023);
        add_row(CMD_QUERY, 1, 0, 0);
        add_row(CMD_QUERY, 0, 1023, 1023);
        settle();

        write_limit(500);
        add_row(CMD_ADD, 500, 501, 0);
        add_row(CMD_ADD, 1023, 0, 0);
        add_row(CMD_QUERY, 1023, 0, 0);
        add_row(CMD_QUERY, 500, 0, 0);
        settle();

        // No idling, with a long output hold-off to back up the input
        write_limit(1023);
        send_gap_pct = 0;
        stall_pct    = 0;
        hold_arm     = 1'b1;
        queue_random(400, 1023);
        settle();

        write_limit(63);
        send_gap_pct = 46;
        stall_pct    = 0;
        queue_random(400, 63);
        settle();

        write_limit(511);
        send_gap_pct = 0;
        stall_pct    = 46;
        queue_random(400, 511);
        settle();

        write_limit(1023);
        send_gap_pct = 26;
        stall_pct    = 26;
        queue_random(400, 1023);
        settle();

        // Catch any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_groups.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_groups.size()));

        $display("covered %0d rows in %0d cycles: %0d new, %0d joined, %0d merged,",
                 rows_accepted, cycle_count, outcome_seen[OUTC_NEW],
                 outcome_seen[OUTC_JOIN], outcome_seen[OUTC_MERGE]);
        $display("%0d rejected, %0d queries, %0d node_limit writes, one long hold-off",
                 outcome_seen[OUTC_ERR], outcome_seen[OUTC_QUERY], limit_writes);
        if (fail_count == 0)
            $display("triple_union_component_labeler_core verification clean");
        else
            $display("triple_union_component_labeler_core verification failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/tucl_pkg.sv
rtl/tucl_ram.sv
rtl/tucl_ctrl.sv
rtl/tucl_dpath.sv
rtl/triple_union_component_labeler_core.sv
sim/tb_triple_union_component_labeler_core.sv
